[src/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request kinds, result status codes, controller states and the control word
// that the controller broadcasts to every queue cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned POS_BITS    = 4;
  localparam int unsigned COUNT_BITS  = 5;

  // Request kinds carried on the input tuser.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_OFFER  = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_DONE  = 2'd2
  } state_e;

  // Commands broadcast to the cell row.
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_OFFER = 3'd1,
    CELL_POLL  = 3'd2,
    CELL_MARK  = 3'd3,
    CELL_SWAP  = 3'd4
  } cell_cmd_e;

  // Control word shared by all cells.
  typedef struct packed {
    cell_cmd_e cmd;
    logic      phase;
    logic      order_mode;
  } cell_ctrl_t;

endpackage

[src/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the queue and exchanges it with its two neighbors for
// inserts, head removal and the odd-even compaction after a tag removal.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned TAG_BITS = 16,
  parameter bit          PARITY   = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                prev_valid_i,
  input  logic                prev_stay_i,
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic [TAG_BITS-1:0] prev_tag_i,
  input  logic                next_valid_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  input  logic [TAG_BITS-1:0] next_tag_i,
  output logic                valid_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0] tag_o,
  output logic                stay_o,
  output logic                match_o
);
  import spq_pkg::*;

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                new_first;

  // The offered key is served strictly before the held key.
  assign new_first = ctrl_i.order_mode ? (new_key_i > key_q) : (new_key_i < key_q);
  assign stay_o    = valid_q & ~new_first;
  assign match_o   = valid_q & (tag_q == new_tag_i);

  // Next entry of this cell.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    case (ctrl_i.cmd)
      CELL_OFFER: begin
        if (!stay_o) begin
          if (prev_stay_i) begin
            valid_d = 1'b1;
            key_d   = new_key_i;
            tag_d   = new_tag_i;
          end else begin
            valid_d = prev_valid_i;
            key_d   = prev_key_i;
            tag_d   = prev_tag_i;
          end
        end
      end
      CELL_POLL: begin
        valid_d = next_valid_i;
        key_d   = next_key_i;
        tag_d   = next_tag_i;
      end
      CELL_MARK: begin
        if (match_o) begin
          valid_d = 1'b0;
        end
      end
      CELL_SWAP: begin
        // In this phase the cell is the left member of a pair when its
        // parity matches; a hole then pulls in a live right neighbor.
        if (PARITY == ctrl_i.phase) begin
          if (!valid_q && next_valid_i) begin
            valid_d = 1'b1;
            key_d   = next_key_i;
            tag_d   = next_tag_i;
          end
        end else if (!prev_valid_i && valid_q) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign tag_o   = tag_q;

endmodule

[src/spq_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue result buffer
// Output register with a skid stage, so a new request can be taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
module spq_obuf #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [WIDTH-1:0] skid_data_q, skid_data_d;
  logic             out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // Refill the output from the skid stage first, then from a new push.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push_i;
        skid_data_d  = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign room_o      = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A push never lands on a full skid stage that cannot drain.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && skid_valid_q |-> out_free)
    else $error("result pushed while the buffer was full");

endmodule

[src/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// Offer, poll and unused kinds: result pushed to the result buffer on accept, and
//   a new one of these requests can be taken every cycle while the buffer has room.
// Remove by tag: matches marked on accept; the odd-even compaction then moves the
//   freed cells to the row tail, one phase per cycle, before the result is pushed.
// Reset empties the queue (all cell valid bits clear) and selects
//   smallest-key-first order; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sorted priority queue core
// A row of DEPTH cells holds the entries in service order with the head in
// cell 0; a small controller broadcasts offer, poll and remove commands.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned TAG_BITS = 16,
  localparam int unsigned IN_W    = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = spq_pkg::POS_BITS + 2 * KEY_BITS + 2 * TAG_BITS
                                    + 2 * spq_pkg::COUNT_BITS + 1,
  localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: order_mode.
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  // Request stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata fields from bit 0: entry_key, entry_tag, zero pad.
  input  logic [IN_W-1:0]                 s_axis_tdata_i,
  // tuser fields from bit 0: kind.
  input  logic [spq_pkg::KIND_BITS-1:0]   s_axis_tuser_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata fields from bit 0: insert_position, taken_key, taken_tag, removed_count,
  // entry_count, head_valid, head_key, head_tag, zero pad.
  output logic [OUT_W-1:0]                m_axis_tdata_o,
  // tuser fields from bit 0: status.
  output logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser_o
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned BUF_W = STATUS_BITS + OUT_W;

  // Cell row signals.
  logic [DEPTH-1:0]    valid_vec, stay_vec, match_vec, first_vec;
  logic [DEPTH-1:0]    prev_valid, prev_stay, next_valid;
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  logic [KEY_BITS-1:0] prev_key [DEPTH];
  logic [TAG_BITS-1:0] prev_tag [DEPTH];
  logic [KEY_BITS-1:0] next_key [DEPTH];
  logic [TAG_BITS-1:0] next_tag [DEPTH];
  cell_ctrl_t          ctrl;

  // Controller state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rm_q, rm_d;
  logic [DEPTH-1:0] match_q, match_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic             order_q;

  // Request fields and result fields.
  logic [KEY_BITS-1:0]   in_key;
  logic [TAG_BITS-1:0]   in_tag;
  logic                  accept, full;
  logic [IDX_W-1:0]      pos_idx;
  status_e               r_status;
  logic [POS_BITS-1:0]   r_pos;
  logic [KEY_BITS-1:0]   r_tkey, r_hkey;
  logic [TAG_BITS-1:0]   r_ttag, r_htag;
  logic [COUNT_BITS-1:0] r_removed, r_count;
  logic                  r_hvalid;
  logic                  push, room;
  logic [BUF_W-1:0]      push_data, out_data;

  assign in_key = s_axis_tdata_i[KEY_BITS-1:0];
  assign in_tag = s_axis_tdata_i[KEY_BITS +: TAG_BITS];
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign full   = (count_q == CNT_W'(DEPTH));

  // Cell row with neighbor links; cell 0 sees an always-kept entry before it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign prev_stay[i]  = 1'b1;
      assign prev_key[i]   = '0;
      assign prev_tag[i]   = '0;
    end else begin : g_link
      assign prev_valid[i] = valid_vec[i-1];
      assign prev_stay[i]  = stay_vec[i-1];
      assign prev_key[i]   = cell_key[i-1];
      assign prev_tag[i]   = cell_tag[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_valid[i] = 1'b0;
      assign next_key[i]   = '0;
      assign next_tag[i]   = '0;
    end else begin : g_next
      assign next_valid[i] = valid_vec[i+1];
      assign next_key[i]   = cell_key[i+1];
      assign next_tag[i]   = cell_tag[i+1];
    end
    assign first_vec[i] = ~stay_vec[i] & prev_stay[i];

    spq_cell #(
      .KEY_BITS(KEY_BITS),
      .TAG_BITS(TAG_BITS),
      .PARITY  (1'(i % 2))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_key_i   (in_key),
      .new_tag_i   (in_tag),
      .prev_valid_i(prev_valid[i]),
      .prev_stay_i (prev_stay[i]),
      .prev_key_i  (prev_key[i]),
      .prev_tag_i  (prev_tag[i]),
      .next_valid_i(next_valid[i]),
      .next_key_i  (next_key[i]),
      .next_tag_i  (next_tag[i]),
      .valid_o     (valid_vec[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i]),
      .stay_o      (stay_vec[i]),
      .match_o     (match_vec[i])
    );
  end

  // Insert position: the single cell where kept entries end.
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  // Controller: next state, cell commands and the result of each request.
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    rm_d            = rm_q;
    match_d         = match_q;
    sweep_d         = sweep_q;
    ctrl.cmd        = CELL_HOLD;
    ctrl.phase      = sweep_q[0];
    ctrl.order_mode = order_q;
    push            = 1'b0;
    r_status        = STAT_DONE;
    r_pos           = '0;
    r_tkey          = '0;
    r_ttag          = '0;
    r_removed       = '0;
    r_hvalid        = valid_vec[0];
    r_hkey          = valid_vec[0] ? cell_key[0] : '0;
    r_htag          = valid_vec[0] ? cell_tag[0] : '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (s_axis_tuser_i)
            KIND_OFFER: begin
              if (full) begin
                r_status = STAT_FULL;
              end else begin
                ctrl.cmd = CELL_OFFER;
                count_d  = count_q + CNT_W'(1);
                r_pos    = POS_BITS'(pos_idx);
                r_hvalid = 1'b1;
                if (first_vec[0]) begin
                  r_hkey = in_key;
                  r_htag = in_tag;
                end
              end
            end
            KIND_POLL: begin
              if (!valid_vec[0]) begin
                r_status = STAT_EMPTY;
              end else begin
                ctrl.cmd = CELL_POLL;
                count_d  = count_q - CNT_W'(1);
                r_tkey   = cell_key[0];
                r_ttag   = cell_tag[0];
                r_hvalid = valid_vec[1];
                r_hkey   = valid_vec[1] ? cell_key[1] : '0;
                r_htag   = valid_vec[1] ? cell_tag[1] : '0;
              end
            end
            KIND_REMOVE: begin
              // Mark matches now, report after the compaction.
              push     = 1'b0;
              ctrl.cmd = CELL_MARK;
              match_d  = match_vec;
              rm_d     = '0;
              sweep_d  = '0;
              state_d  = S_SWEEP;
            end
            default: begin
              r_status = STAT_DONE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        // One odd-even phase per cycle; count the marked cells meanwhile.
        ctrl.cmd = CELL_SWAP;
        rm_d     = rm_q + CNT_W'(match_q[0]);
        match_d  = match_q >> 1;
        sweep_d  = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(DEPTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        push      = 1'b1;
        count_d   = count_q - rm_q;
        r_removed = COUNT_BITS'(rm_q);
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign r_count   = COUNT_BITS'(count_d);
  assign push_data = {OUT_W'({r_htag, r_hkey, r_hvalid, r_count, r_removed,
                              r_ttag, r_tkey, r_pos}), r_status};

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rm_q    <= '0;
      match_q <= '0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rm_q    <= rm_d;
      match_q <= match_d;
      sweep_q <= sweep_d;
    end
  end

  // Order mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE) & room;

  // Result buffer.
  spq_obuf #(
    .WIDTH(BUF_W)
  ) u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out_data)
  );

  assign m_axis_tuser_o = out_data[STATUS_BITS-1:0];
  assign m_axis_tdata_o = out_data[BUF_W-1:STATUS_BITS];

  // Between requests the live cells match the entry count.
  a_count_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(valid_vec) == int'(count_q))
    else $error("cell occupancy differs from entry count");

  // Between requests the head cell is live exactly when the queue holds entries.
  a_head_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> valid_vec[0] == (count_q != '0))
    else $error("head cell empty while queue holds entries");

  // A remove request always starts the compaction sweep.
  a_remove_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser_i == KIND_REMOVE |=> state_q == S_SWEEP && sweep_q == '0)
    else $error("remove request did not start the sweep");

  // An accepted offer on a full queue leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser_i == KIND_OFFER && full |=> $stable(count_q))
    else $error("refused offer changed the entry count");

endmodule

[dv/tb_sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// A shadow queue predicts every result and checks it field by field. The run
// has a directed part: an empty queue, a full queue, key ties and the widest
// values. It then runs random phases in both service orders. The sender
// works in bursts, and the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned IN_W     = 48;
  localparam int unsigned OUT_W    = 112;

  // Kind code that the block treats as no operation.
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  // Idle cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 3000;
  // Length of the long receiver hold-off and the result count that starts it.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT     = 450;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef struct {
    logic [KIND_BITS-1:0] kind;
    logic [KEY_BITS-1:0]  key;
    logic [TAG_BITS-1:0]  tag;
  } request_t;

  // Result tdata layout, highest field first.
  typedef struct packed {
    logic                  pad;
    logic [TAG_BITS-1:0]   head_tag;
    logic [KEY_BITS-1:0]   head_key;
    logic                  head_valid;
    logic [COUNT_BITS-1:0] entry_count;
    logic [COUNT_BITS-1:0] removed_count;
    logic [TAG_BITS-1:0]   taken_tag;
    logic [KEY_BITS-1:0]   taken_key;
    logic [POS_BITS-1:0]   insert_position;
  } result_word_t;

  typedef struct packed {
    status_e               status;
    logic [POS_BITS-1:0]   insert_position;
    logic [KEY_BITS-1:0]   taken_key;
    logic [TAG_BITS-1:0]   taken_tag;
    logic [COUNT_BITS-1:0] removed_count;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  head_valid;
    logic [KEY_BITS-1:0]   head_key;
    logic [TAG_BITS-1:0]   head_tag;
  } queue_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i        = 1'b0;
  logic                   cfg_wdata_i     = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i  = '0;
  logic [KIND_BITS-1:0]   s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata_o;
  logic [STATUS_BITS-1:0] m_axis_tuser_o;

  result_word_t rx_word;
  assign rx_word = m_axis_tdata_o;

  // Requests waiting to be sent and results waiting to arrive.
  request_t      pending_requests[$];
  queue_result_t expected_results[$];

  // Shadow copy of the queue contents and the service order.
  logic [KEY_BITS-1:0] shadow_key[DEPTH];
  logic [TAG_BITS-1:0] shadow_tag[DEPTH];
  int unsigned         shadow_count = 0;
  logic                shadow_order = 1'b0;

  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  request_t    sent_request;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;

  sorted_priority_queue_core #(
    .DEPTH   (DEPTH),
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // True when key a leaves the queue strictly ahead of key b.
  function automatic bit served_first(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    return shadow_order ? (a > b) : (a < b);
  endfunction

  // Apply one accepted request to the shadow queue and record its result.
  task automatic apply_request(input request_t rq);
    queue_result_t res;
    int            spot;
    int            kept;
    res        = '0;
    res.status = STAT_DONE;
    case (rq.kind)
      KIND_OFFER: begin
        if (shadow_count == DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // The new entry goes after every entry that is served before or with it.
          spot = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (served_first(rq.key, shadow_key[i])) spot = i;
          end
          for (int i = shadow_count; i > spot; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[spot] = rq.key;
          shadow_tag[spot] = rq.tag;
          shadow_count++;
          res.insert_position = POS_BITS'(spot);
        end
      end
      KIND_POLL: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.taken_key = shadow_key[0];
          res.taken_tag = shadow_tag[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_key[i-1] = shadow_key[i];
            shadow_tag[i-1] = shadow_tag[i];
          end
          shadow_count--;
        end
      end
      KIND_REMOVE: begin
        // Compact the survivors toward the head, keeping their order.
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_tag[i] == rq.tag) begin
            res.removed_count++;
          end else begin
            shadow_key[kept] = shadow_key[i];
            shadow_tag[kept] = shadow_tag[i];
            kept++;
          end
        end
        shadow_count = kept;
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_BITS'(shadow_count);
    if (shadow_count > 0) begin
      res.head_valid = 1'b1;
      res.head_key   = shadow_key[0];
      res.head_tag   = shadow_tag[0];
    end
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [KEY_BITS-1:0] exp_val,
                             input logic [KEY_BITS-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  function automatic void queue_request(logic [KIND_BITS-1:0] kind, logic [KEY_BITS-1:0] key,
                                        logic [TAG_BITS-1:0] tag);
    request_t rq;
    rq.kind = kind;
    rq.key  = key;
    rq.tag  = tag;
    pending_requests.push_back(rq);
  endfunction

  // Random requests; the offer share drifts so the queue swings between
  // empty and full. Small key and tag pools give ties and matching removes.
  function automatic void queue_random_requests(int unsigned count);
    int unsigned      offer_pct;
    int unsigned      pick;
    logic [KIND_BITS-1:0] kind;
    logic [KEY_BITS-1:0]  key;
    logic [TAG_BITS-1:0]  tag;
    offer_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       offer_pct = 80;
          1:       offer_pct = 50;
          default: offer_pct = 25;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kind = KIND_UNUSED;
      end else if (pick < 12) begin
        kind = KIND_REMOVE;
      end else if ($urandom_range(0, 99) < offer_pct) begin
        kind = KIND_OFFER;
      end else begin
        kind = KIND_POLL;
      end
      case ($urandom_range(0, 9))
        0:          key = '0;
        1:          key = '1;
        2, 3, 4, 5: key = KEY_BITS'($urandom_range(0, 15));
        default:    key = KEY_BITS'($urandom);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        tag = TAG_BITS'($urandom_range(0, 65535));
      end else begin
        tag = TAG_BITS'($urandom_range(0, 7));
      end
      queue_request(kind, key, tag);
    end
  endfunction

  // Enough polls to empty the queue from any fill level.
  function automatic void queue_drain();
    for (int unsigned n = 0; n <= DEPTH; n++) begin
      queue_request(KIND_POLL, KEY_BITS'($urandom), TAG_BITS'($urandom));
    end
  endfunction

  // Wait until every request is sent and every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_order(input logic mode);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= mode;
    shadow_order  = mode;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
  endtask

  // Request driver: bursts of random length with random gaps between them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) apply_request(sent_request);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left        <= gap_left - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          sent_request     = pending_requests.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {sent_request.tag, sent_request.key};
          s_axis_tuser_i  <= sent_request.kind;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result ready: the stall pattern is picked at random from three modes, and once the
  // receiver holds off long enough for the queue to back up its input.
  int unsigned rx_cycle  = 0;
  int unsigned rx_mode   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 50 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left       <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done       <= 1'b1;
        hold_left       <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("status", KEY_BITS'(exp_res.status), KEY_BITS'(m_axis_tuser_o));
        check_field("insert_position", KEY_BITS'(exp_res.insert_position),
                    KEY_BITS'(rx_word.insert_position));
        check_field("taken_key", exp_res.taken_key, rx_word.taken_key);
        check_field("taken_tag", KEY_BITS'(exp_res.taken_tag), KEY_BITS'(rx_word.taken_tag));
        check_field("removed_count", KEY_BITS'(exp_res.removed_count),
                    KEY_BITS'(rx_word.removed_count));
        check_field("entry_count", KEY_BITS'(exp_res.entry_count),
                    KEY_BITS'(rx_word.entry_count));
        check_field("head_valid", KEY_BITS'(exp_res.head_valid), KEY_BITS'(rx_word.head_valid));
        check_field("head_key", exp_res.head_key, rx_word.head_key);
        check_field("head_tag", KEY_BITS'(exp_res.head_tag), KEY_BITS'(rx_word.head_tag));
      end
    end
  end

  // Watchdog on cycles in which neither side completes a handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_priority_queue_core regression: fail");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_order(1'b0);

    // Empty queue: poll, remove and the unused kind.
    queue_request(KIND_POLL, '0, '0);
    queue_request(KIND_REMOVE, '1, '0);
    queue_request(KIND_UNUSED, '1, '1);
    // Fill the queue with ties, extreme keys and mostly one tag.
    queue_request(KIND_OFFER, 32'd7, 16'hFFFF);
    queue_request(KIND_OFFER, 32'd7, 16'd1);
    queue_request(KIND_OFFER, 32'd0, 16'hFFFF);
    queue_request(KIND_OFFER, '1, 16'hFFFF);
    queue_request(KIND_OFFER, 32'd7, 16'hFFFF);
    queue_request(KIND_OFFER, 32'd3, 16'd2);
    queue_request(KIND_OFFER, '1, 16'd0);
    for (int k = 1; k <= 8; k++) queue_request(KIND_OFFER, 32'd7 + k, 16'hFFFF);
    queue_request(KIND_OFFER, '1, 16'hFFFF);
    // Full queue: refused offer, then unused kind and a remove with no match.
    queue_request(KIND_OFFER, 32'd5, 16'd3);
    queue_request(KIND_UNUSED, 32'd5, 16'd3);
    queue_request(KIND_REMOVE, '1, 16'h1234);
    queue_request(KIND_POLL, '0, '0);
    queue_request(KIND_REMOVE, '0, 16'hFFFF);
    queue_request(KIND_POLL, '0, '0);
    queue_drain();
    wait_idle();

    // Random phases alternating the service order.
    for (int ph = 0; ph < 4; ph++) begin
      set_order(ph % 2 == 0);
      queue_random_requests(PHASE_ITEMS);
      queue_drain();
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sorted_priority_queue_core regression: pass");
    end else begin
      $display("sorted_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/spq_pkg.sv
src/spq_cell.sv
src/spq_obuf.sv
src/sorted_priority_queue_core.sv
dv/tb_sorted_priority_queue_core.sv
